// ===== src/rspm_pkg.sv =====
// Shared types and constants for the rolling sum pattern matcher.
package rspm_pkg;

  localparam int PAT_REG_BYTES = 32;   // pattern bytes held in config registers
  localparam int LEN_W         = 6;
  localparam int IDX_W         = 5;    // index into the 32 pattern bytes
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int LINE_W        = 24;
  localparam int COL_W         = 16;

  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI     = 3'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } in_beat_t;

  typedef struct packed {
    logic [LINE_W-1:0] match_line;
    logic [COL_W-1:0]  match_column;
  } out_beat_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef logic [PAT_REG_BYTES-1:0][7:0] pat_bytes_t;

endpackage

// ===== src/rspm_cell.sv =====
// One window cell: holds one text byte and its aligned pattern byte.
module rspm_cell
  import rspm_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [7:0]       byte_in,
  output logic [7:0]       byte_out,
  input  pat_bytes_t       pat_bytes,
  input  logic [IDX_W-1:0] len_m1,
  output logic             hit
);

  localparam logic [IDX_W-1:0] IDX_V = IDX[IDX_W-1:0];

  logic [7:0]       byte_r, byte_nxt;
  logic [7:0]       pat_r, pat_nxt;
  logic             en_r, en_nxt;
  logic [IDX_W-1:0] pidx;

  // window slot IDX lines up with pattern byte len-1-IDX
  always_comb begin
    pidx    = len_m1 - IDX_V;
    en_nxt  = (IDX_V <= len_m1);
    pat_nxt = pat_bytes[pidx];
    if (ctl.clear) begin
      byte_nxt = 8'd0;
    end else if (ctl.shift) begin
      byte_nxt = byte_in;
    end else begin
      byte_nxt = byte_r;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    pat_r  <= pat_nxt;
    en_r   <= en_nxt;
  end

  assign byte_out = byte_r;
  assign hit      = !en_r || (byte_r == pat_r);

endmodule

// ===== src/rolling_sum_pattern_matcher.sv =====
// Top level of the rolling sum pattern matcher: cell row, counters, output stage.
//
// Text enters one byte per beat; a beat with line_end set closes the line.
// The block takes one beat every cycle unless a match waits behind a full
// output register. A byte beat shifts into a row of cells (one per window
// slot), each of which compares its byte against the pattern byte aligned
// to it; the cycle after the beat the row's hit flags are ANDed, and a
// match lands in the output register once it is free, raising out_valid. The
// compare of the full window implies the byte-sum check, so no separate sum
// is kept.
// pattern_length 0 acts as 1; above min(PATTERN_MAX, 32) it is clamped.
// The column is bytes_in_line minus the length; bytes_in_line saturates at
// 65535 and the line number at 16777215. Only back-pressure on the output,
// with a match pending behind a full output register, stalls the input.
module rolling_sum_pattern_matcher
  import rspm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // slots at or above 32 can never be compared, so they are not built
  localparam int NCELL = (PATTERN_MAX < PAT_REG_BYTES) ? PATTERN_MAX : PAT_REG_BYTES;
  localparam logic [LEN_W-1:0] NCELL_V = NCELL[LEN_W-1:0];

  // config registers
  logic [LEN_W-1:0]            len_r, len_nxt;
  logic [3:0][CFG_DATA_W-1:0]  pat_r, pat_nxt;

  // line state
  logic [COL_W-1:0]  cnt_r, cnt_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;

  // compare stage and output stage
  logic      s1_valid_r, s1_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;

  logic             in_acc;
  logic             out_free;
  logic             s1_match;
  logic             s1_go;
  logic [LEN_W-1:0] eff_len;
  logic [IDX_W-1:0] len_m1;
  pat_bytes_t       pat_bytes;
  cell_ctl_t        ctl;
  logic [7:0]       chain [NCELL+1];
  logic [NCELL-1:0] hits;

  assign pat_bytes = pat_r;

  always_comb begin
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_r > NCELL_V) begin
      eff_len = NCELL_V;
    end else begin
      eff_len = len_r;
    end
  end
  assign len_m1 = IDX_W'(eff_len - LEN_W'(1));

  // ---- cell row: chain[0] is the incoming byte, chain[i+1] is slot i
  assign chain[0]  = in_data.text_byte;
  assign ctl.shift = in_acc && !in_data.line_end;
  assign ctl.clear = in_acc && in_data.line_end;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rspm_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .byte_in   (chain[i]),
      .byte_out  (chain[i+1]),
      .pat_bytes (pat_bytes),
      .len_m1    (len_m1),
      .hit       (hits[i])
    );
  end

  // ---- handshake
  assign out_free = !out_valid_r || out_ready;
  // window and counters stay still while a match in the compare stage waits for the output register
  assign s1_match = s1_valid_r && (&hits) && (cnt_r >= {{(COL_W-LEN_W){1'b0}}, eff_len});
  assign s1_go    = !s1_match || out_free;
  assign in_ready = !s1_valid_r || s1_go;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    len_nxt       = len_r;
    pat_nxt       = pat_r;
    cnt_nxt       = cnt_r;
    line_nxt      = line_r;
    s1_valid_nxt  = s1_valid_r && !s1_go;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAT_LEN:    len_nxt    = cfg_wdata[LEN_W-1:0];
        CFG_PAT_LO:     pat_nxt[0] = cfg_wdata;
        CFG_PAT_MID_LO: pat_nxt[1] = cfg_wdata;
        CFG_PAT_MID_HI: pat_nxt[2] = cfg_wdata;
        CFG_PAT_HI:     pat_nxt[3] = cfg_wdata;
        default: ;
      endcase
    end

    if (in_acc) begin
      s1_valid_nxt = !in_data.line_end;
      if (in_data.line_end) begin
        cnt_nxt = '0;
        if (line_r != LINE_MAX) begin
          line_nxt = line_r + LINE_W'(1);
        end
      end else if (cnt_r != COL_MAX) begin
        cnt_nxt = cnt_r + COL_W'(1);
      end
    end

    if (s1_match && out_free) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.match_line   = line_r;
      out_data_nxt.match_column = cnt_r - {{(COL_W-LEN_W){1'b0}}, eff_len};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_W'(1);
      pat_r       <= '0;
      cnt_r       <= '0;
      line_r      <= LINE_W'(1);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      pat_r       <= pat_nxt;
      cnt_r       <= cnt_nxt;
      line_r      <= line_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/rspm_checker.sv =====
// Port-level checks for the rolling sum pattern matcher, bound to the top level.
module rspm_checker
  import rspm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_beat_t             out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  // input stalls only behind a stalled output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with output free");

  // line counts from 1, column leaves room for at least one byte
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.match_line != '0 && out_data.match_column != COL_MAX)
    else $error("result out of range");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  // just after reset, a result needs a byte accepted before it
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |=> !out_valid || $past(in_valid && in_ready))
    else $error("result without an accepted byte");

endmodule

bind rolling_sum_pattern_matcher rspm_checker u_rspm_checker (.*);
